@@ hdl/cftp_pkg.sv @@
// Shared constants, face codes and lookup functions for the cube face projection.
package cftp_pkg;

  localparam int ANGLE_W    = 16;
  localparam int COORD_FRAC = 14;
  localparam int COORD_W    = COORD_FRAC + 2;
  localparam int FACE_W     = 3;
  localparam int LON_W      = 9;
  localparam int LAT_W      = 8;

  // Q30 one and pi/2 in Q31
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [31:0] HALF_PI   = 32'd3373259426;

  // pipeline depths
  localparam int SC_LAT  = 12;
  localparam int DIV_LAT = COORD_FRAC + 3;

  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
  localparam logic [FACE_W-1:0] FACE_EQ0    = 3'd1;
  localparam logic [FACE_W-1:0] FACE_EQ90   = 3'd2;
  localparam logic [FACE_W-1:0] FACE_EQ180  = 3'd3;
  localparam logic [FACE_W-1:0] FACE_EQ270  = 3'd4;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

  function automatic logic [LON_W-1:0] center_lon(input logic [FACE_W-1:0] f);
    logic [LON_W-1:0] r;
    unique case (f)
      FACE_EQ90:  r = 9'd90;
      FACE_EQ180: r = 9'd180;
      FACE_EQ270: r = 9'd270;
      default:    r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [LAT_W-1:0] center_lat(input logic [FACE_W-1:0] f);
    logic signed [LAT_W-1:0] r;
    unique case (f)
      FACE_TOP:    r = 8'sd90;
      FACE_BOTTOM: r = -8'sd90;
      default:     r = 8'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/cftp_sincos.sv @@
// Pipelined sine and cosine of a binary angle, Taylor series in Q30.
module cftp_sincos (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [cftp_pkg::ANGLE_W-1:0] angle_i,
  output logic                         out_valid_o,
  output logic signed [31:0]           sin_o,
  output logic signed [31:0]           cos_o
);
  import cftp_pkg::*;

  localparam int RW = ANGLE_W - 2;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } side_t;

  localparam int SIN_DIV [4] = '{72, 42, 20, 6};
  localparam int SIN_SH  [4] = '{7, 6, 5, 3};
  localparam int COS_DIV [4] = '{90, 56, 30, 12};
  localparam int COS_SH  [4] = '{7, 6, 5, 4};

  // floor(v / d) by a reciprocal; exact for v below 2^31
  function automatic logic [30:0] div_c(input logic [30:0] v, input logic [31:0] m,
                                        input int sh);
    logic [62:0] p;
    p = 63'(v) * 63'(m);
    return 31'(p >> (31 + sh));
  endfunction

  logic [SC_LAT-1:0] vld_q;
  logic [RW-1:0]     r0_q;
  logic [1:0]        quad0_q;
  logic              swap0_q;
  side_t             side_q [1:SC_LAT-2];
  logic [30:0]       ts_q [4];
  logic [30:0]       tc_q [4];
  logic [30:0]       ps_q [4];
  logic [30:0]       pc_q [4];

  logic [RW-1:0] rr;
  logic [RW:0]   full;
  logic          fold;
  logic [RW+31:0] xprod;
  logic [59:0]   xsq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SC_LAT-2:0], in_valid_i};
    end
  end

  // octant fold
  assign rr   = angle_i[RW-1:0];
  assign full = (RW+1)'(1) << RW;
  assign fold = rr > (RW'(1) << (RW - 1));

  always_ff @(posedge clk_i) begin
    quad0_q <= angle_i[ANGLE_W-1 -: 2];
    swap0_q <= fold;
    r0_q    <= fold ? RW'(full - {1'b0, rr}) : rr;
  end

  assign xprod = (RW+32)'(r0_q) * (RW+32)'(HALF_PI);
  assign xsq   = 60'(side_q[1].x) * 60'(side_q[1].x);

  always_ff @(posedge clk_i) begin
    side_q[1] <= '{x: xprod[ANGLE_W-1 +: 30], x2: '0, quad: quad0_q, swap: swap0_q};
    side_q[2] <= '{x: side_q[1].x, x2: xsq[59:30], quad: side_q[1].quad,
                   swap: side_q[1].swap};
    for (int j = 3; j <= SC_LAT - 2; j++) begin
      side_q[j] <= side_q[j-1];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_step
    localparam logic [63:0] MS = ((64'd1 << (31 + SIN_SH[k])) + 64'(SIN_DIV[k]) - 64'd1)
                                 / 64'(SIN_DIV[k]);
    localparam logic [63:0] MC = ((64'd1 << (31 + COS_SH[k])) + 64'(COS_DIV[k]) - 64'd1)
                                 / 64'(COS_DIV[k]);
    logic [30:0] in_s, in_c;
    logic [60:0] prod_s, prod_c;

    if (k == 0) begin : g_first
      assign in_s = {1'b0, side_q[2].x2};
      assign in_c = {1'b0, side_q[2].x2};
    end else begin : g_next
      assign in_s = ps_q[k-1];
      assign in_c = pc_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      ts_q[k] <= Q30_ONE - div_c(in_s, MS[31:0], SIN_SH[k]);
      tc_q[k] <= Q30_ONE - div_c(in_c, MC[31:0], COS_SH[k]);
    end

    if (k == 3) begin : g_last
      assign prod_s = 61'(side_q[3+2*k].x) * 61'(ts_q[k]);
      assign prod_c = 61'(side_q[3+2*k].x2) * 61'(tc_q[k]);
      always_ff @(posedge clk_i) begin
        ps_q[k] <= prod_s[60:30];
        pc_q[k] <= Q30_ONE - (prod_c[60:30] >> 1);
      end
    end else begin : g_mid
      assign prod_s = 61'(side_q[3+2*k].x2) * 61'(ts_q[k]);
      assign prod_c = 61'(side_q[3+2*k].x2) * 61'(tc_q[k]);
      always_ff @(posedge clk_i) begin
        ps_q[k] <= prod_s[60:30];
        pc_q[k] <= prod_c[60:30];
      end
    end
  end

  // unfold: octant swap, then quadrant sign
  logic signed [31:0] sv, cv;
  assign sv = side_q[SC_LAT-2].swap ? $signed({1'b0, pc_q[3]}) : $signed({1'b0, ps_q[3]});
  assign cv = side_q[SC_LAT-2].swap ? $signed({1'b0, ps_q[3]}) : $signed({1'b0, pc_q[3]});

  always_ff @(posedge clk_i) begin
    unique case (side_q[SC_LAT-2].quad)
      2'd0: begin sin_o <= sv;  cos_o <= cv;  end
      2'd1: begin sin_o <= cv;  cos_o <= -sv; end
      2'd2: begin sin_o <= -sv; cos_o <= -cv; end
      default: begin sin_o <= -cv; cos_o <= sv; end
    endcase
  end

  assign out_valid_o = vld_q[SC_LAT-1];

endmodule

@@ hdl/cftp_div.sv @@
// Pipelined rounded divide, one quotient bit per stage, saturated to +-1.
module cftp_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic signed [31:0]                  num_i,
  input  logic signed [31:0]                  den_i,
  output logic                                out_valid_o,
  output logic signed [cftp_pkg::COORD_W-1:0] quot_o
);
  import cftp_pkg::*;

  localparam int QB    = COORD_FRAC + 1;
  localparam int REM_W = 32 + COORD_FRAC + 1;

  logic [DIV_LAT-1:0] vld_q;
  logic [REM_W-1:0]   rem_q [QB+1];
  logic [QB-1:0]      q_q   [QB+1];
  logic [30:0]        den_q [QB+1];
  logic               neg_q [QB+1];
  logic               dpos_q[QB+1];

  logic [31:0] un;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_LAT-2:0], in_valid_i};
    end
  end

  assign un = num_i[31] ? 32'(-num_i) : 32'(num_i);

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= (REM_W'(un) << COORD_FRAC) + REM_W'(den_i[30:1]);
    q_q[0]    <= '0;
    den_q[0]  <= den_i[30:0];
    neg_q[0]  <= num_i[31];
    dpos_q[0] <= !den_i[31] && (den_i != '0);
  end

  for (genvar k = 1; k <= QB; k++) begin : g_bit
    localparam int B = QB - k;
    logic [REM_W:0] trial;
    assign trial = {1'b0, rem_q[k-1]} - ((REM_W+1)'(den_q[k-1]) << B);
    always_ff @(posedge clk_i) begin
      rem_q[k]    <= trial[REM_W] ? rem_q[k-1] : trial[REM_W-1:0];
      q_q[k]      <= q_q[k-1] | (QB'(!trial[REM_W]) << B);
      den_q[k]    <= den_q[k-1];
      neg_q[k]    <= neg_q[k-1];
      dpos_q[k]   <= dpos_q[k-1];
    end
  end

  logic [QB-1:0] qs;
  assign qs = (q_q[QB] > (QB'(1) << COORD_FRAC)) ? (QB'(1) << COORD_FRAC) : q_q[QB];

  always_ff @(posedge clk_i) begin
    if (!dpos_q[QB]) begin
      quot_o <= '0;
    end else if (neg_q[QB]) begin
      quot_o <= -$signed(COORD_W'(qs));
    end else begin
      quot_o <= $signed(COORD_W'(qs));
    end
  end

  assign out_valid_o = vld_q[DIV_LAT-1];

endmodule

@@ hdl/cube_face_tangent_projection_top.sv @@
// Top level of the spherical cube face selection and gnomonic projection.
//
// Usage:
//   Input channel: drive longitude_i (unsigned binary angle, 65536 = one
//   turn) and latitude_i (signed, +-16384 = +-90 deg) and raise start. The
//   item is taken at each clock edge where start is high and busy is low.
//   busy stays low: the pipeline takes one item every cycle.
//   Result channel: done_o is high for exactly one cycle with face_o,
//   chi_o, psi_o (signed Q1.14), center_longitude_o and center_latitude_o.
//   The receiver cannot hold results off, and none is needed since nothing
//   in the pipeline ever stalls.
// Pipeline: from the accepting edge to the edge that takes the result, the
//   sine/cosine series (two Horner chains of four divide/multiply steps),
//   then the l/m products, then face selection, then the one-bit-per-stage
//   rounded divider.
// Throughput: one item per cycle, results in input order.
// Reset: clears only the valid bits; items in flight are dropped.
module cube_face_tangent_projection_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [cftp_pkg::ANGLE_W-1:0]         longitude_i,
  input  logic signed [cftp_pkg::ANGLE_W-1:0]  latitude_i,
  output logic                                 done_o,
  output logic [cftp_pkg::FACE_W-1:0]          face_o,
  output logic signed [cftp_pkg::COORD_W-1:0]  chi_o,
  output logic signed [cftp_pkg::COORD_W-1:0]  psi_o,
  output logic [cftp_pkg::LON_W-1:0]           center_longitude_o,
  output logic signed [cftp_pkg::LAT_W-1:0]    center_latitude_o
);
  import cftp_pkg::*;

  localparam int LAT_TOTAL = SC_LAT + 2 + DIV_LAT;

  // signed Q30 product, magnitude truncated
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [31:0] ua, ub, pm;
    logic [63:0] p;
    ua = a[31] ? 32'(-a) : 32'(a);
    ub = b[31] ? 32'(-b) : 32'(b);
    p  = 64'(ua) * 64'(ub);
    pm = p[61:30];
    return (a[31] != b[31]) ? -$signed(pm) : $signed(pm);
  endfunction

  logic sc_vld, sc_vld_lat;
  logic signed [31:0] sp, cp, st, ct;

  assign busy = 1'b0;

  cftp_sincos u_sc_lon (
    .clk_i, .rst_ni,
    .in_valid_i (start && !busy),
    .angle_i    (longitude_i),
    .out_valid_o(sc_vld),
    .sin_o      (sp),
    .cos_o      (cp)
  );

  cftp_sincos u_sc_lat (
    .clk_i, .rst_ni,
    .in_valid_i (start && !busy),
    .angle_i    (latitude_i),
    .out_valid_o(sc_vld_lat),
    .sin_o      (st),
    .cos_o      (ct)
  );

  // direction vector
  logic               v1_q;
  logic signed [31:0] l_q, m_q, n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= sc_vld && sc_vld_lat;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q <= mul_q30(ct, cp);
    m_q <= mul_q30(ct, sp);
    n_q <= st;
  end

  // face pick: largest component, lowest index on ties
  logic signed [31:0] zeta [6];
  logic signed [31:0] xi   [6];
  logic signed [31:0] eta  [6];
  logic signed [31:0] best;
  logic [FACE_W-1:0]  fsel;

  always_comb begin
    zeta = '{n_q, l_q, m_q, -l_q, -m_q, -n_q};
    xi   = '{m_q, m_q, -l_q, -m_q, l_q, m_q};
    eta  = '{-l_q, n_q, n_q, n_q, n_q, l_q};
    best = zeta[0];
    fsel = FACE_TOP;
    for (int k = 1; k < 6; k++) begin
      if (zeta[k] > best) begin
        best = zeta[k];
        fsel = FACE_W'(k);
      end
    end
  end

  logic               v2_q;
  logic [FACE_W-1:0]  face2_q;
  logic signed [31:0] xi2_q, eta2_q, den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    face2_q <= fsel;
    xi2_q   <= xi[fsel];
    eta2_q  <= eta[fsel];
    den2_q  <= best;
  end

  // face code rides alongside the dividers
  logic [FACE_W-1:0] face_dly_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    face_dly_q[0] <= face2_q;
    for (int j = 1; j < DIV_LAT; j++) begin
      face_dly_q[j] <= face_dly_q[j-1];
    end
  end

  logic chi_vld, psi_vld;

  cftp_div u_div_chi (
    .clk_i, .rst_ni,
    .in_valid_i (v2_q),
    .num_i      (xi2_q),
    .den_i      (den2_q),
    .out_valid_o(chi_vld),
    .quot_o     (chi_o)
  );

  cftp_div u_div_psi (
    .clk_i, .rst_ni,
    .in_valid_i (v2_q),
    .num_i      (eta2_q),
    .den_i      (den2_q),
    .out_valid_o(psi_vld),
    .quot_o     (psi_o)
  );

  assign done_o             = chi_vld && psi_vld;
  assign face_o             = face_dly_q[DIV_LAT-1];
  assign center_longitude_o = center_lon(face_dly_q[DIV_LAT-1]);
  assign center_latitude_o  = center_lat(face_dly_q[DIV_LAT-1]);

  // every result traces back to an accepted item a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT_TOTAL))
    else $error("result without matching item");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (face_o <= FACE_BOTTOM))
    else $error("face out of range");

  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (chi_o <= 16'sd16384 && chi_o >= -16'sd16384 &&
                psi_o <= 16'sd16384 && psi_o >= -16'sd16384))
    else $error("tangent coordinate beyond unit range");

endmodule

@@ bench/cftp_checker.sv @@
// Checker for the cube face projection: predicts each item's result and compares.
module cftp_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 busy_i,
  input  logic [cftp_pkg::ANGLE_W-1:0]         longitude_i,
  input  logic signed [cftp_pkg::ANGLE_W-1:0]  latitude_i,
  input  logic                                 done_i,
  input  logic [cftp_pkg::FACE_W-1:0]          face_i,
  input  logic signed [cftp_pkg::COORD_W-1:0]  chi_i,
  input  logic signed [cftp_pkg::COORD_W-1:0]  psi_i,
  input  logic [cftp_pkg::LON_W-1:0]           center_longitude_i,
  input  logic signed [cftp_pkg::LAT_W-1:0]    center_latitude_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  import cftp_pkg::*;

  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic [COORD_W-1:0] chi;
    logic [COORD_W-1:0] psi;
    logic [LON_W-1:0]   clon;
    logic [LAT_W-1:0]   clat;
  } proj_t;

  localparam longint unsigned ONE = 64'd1 << 30;

  proj_t proj_q[$];

  // series sine/cosine of a 32-bit turn fraction, Q30
  function automatic void turn_sin_cos(input logic [31:0] a, output longint s_o,
                                       output longint c_o);
    logic [1:0] quad;
    longint unsigned r, x, x2, t, sv, cv, tmp;
    bit swap;
    quad = a[31:30];
    r = a[29:0];
    swap = 1'b0;
    if (r > 64'h2000_0000) begin
      r = 64'h4000_0000 - r;
      swap = 1'b1;
    end
    x  = (r * HALF_PI) >> 31;
    x2 = (x * x) >> 30;
    t  = ONE - x2 / 72;
    t  = ONE - ((x2 * t) >> 30) / 42;
    t  = ONE - ((x2 * t) >> 30) / 20;
    t  = ONE - ((x2 * t) >> 30) / 6;
    sv = (x * t) >> 30;
    t  = ONE - x2 / 90;
    t  = ONE - ((x2 * t) >> 30) / 56;
    t  = ONE - ((x2 * t) >> 30) / 30;
    t  = ONE - ((x2 * t) >> 30) / 12;
    cv = ONE - ((x2 * t) >> 30) / 2;
    if (swap) begin
      tmp = sv; sv = cv; cv = tmp;
    end
    case (quad)
      2'd0: begin s_o = longint'(sv);  c_o = longint'(cv);  end
      2'd1: begin s_o = longint'(cv);  c_o = -longint'(sv); end
      2'd2: begin s_o = -longint'(sv); c_o = -longint'(cv); end
      default: begin s_o = -longint'(cv); c_o = longint'(sv); end
    endcase
  endfunction

  // product truncated toward zero
  function automatic longint q30_mul(input longint a, input longint b);
    longint unsigned ua, ub, p;
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    p = (ua * ub) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // rounded tangent ratio, saturated to +-1
  function automatic logic [COORD_W-1:0] tangent_ratio(input longint num, input longint den);
    longint unsigned un, q;
    longint v;
    if (den <= 0) return '0;
    un = (num < 0) ? longint'(-num) : num;
    q = ((un << COORD_FRAC) + longint'(den) / 2) / den;
    if (q > (64'd1 << COORD_FRAC)) q = 64'd1 << COORD_FRAC;
    v = (num < 0) ? -longint'(q) : longint'(q);
    return v[COORD_W-1:0];
  endfunction

  function automatic proj_t project(input logic [ANGLE_W-1:0] lon, input logic [ANGLE_W-1:0] lat);
    longint sp, cp, st, ct, l, m, n, best;
    longint zeta[6], xi[6], eta[6];
    int f;
    proj_t p;
    turn_sin_cos({lon, 16'h0}, sp, cp);
    turn_sin_cos({lat, 16'h0}, st, ct);
    l = q30_mul(ct, cp);
    m = q30_mul(ct, sp);
    n = st;
    zeta = '{n, l, m, -l, -m, -n};
    xi   = '{m, m, -l, -m, l, m};
    eta  = '{-l, n, n, n, n, l};
    best = zeta[0];
    f = 0;
    for (int k = 1; k < 6; k++)
      if (zeta[k] > best) begin
        best = zeta[k];
        f = k;
      end
    p.face = f[FACE_W-1:0];
    p.chi  = tangent_ratio(xi[f], best);
    p.psi  = tangent_ratio(eta[f], best);
    case (p.face)
      FACE_EQ90:  p.clon = 9'd90;
      FACE_EQ180: p.clon = 9'd180;
      FACE_EQ270: p.clon = 9'd270;
      default:    p.clon = 9'd0;
    endcase
    case (p.face)
      FACE_TOP:    p.clat = 8'd90;
      FACE_BOTTOM: p.clat = 8'hA6;  // -90
      default:     p.clat = 8'd0;
    endcase
    return p;
  endfunction

  always @(posedge clk_i) begin
    proj_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      pending_o = 0;
      proj_q.delete();
    end else begin
      if (done_i) begin
        if (proj_q.size() == 0) begin
          $display("%0t: result with nothing expected: face %0d chi %0d psi %0d",
                   $time, face_i, chi_i, psi_i);
          fail_count_o++;
        end else begin
          want = proj_q.pop_front();
          if (face_i !== want.face || chi_i !== want.chi || psi_i !== want.psi ||
              center_longitude_i !== want.clon || center_latitude_i !== want.clat) begin
            $display("%0t: mismatch expected face %0d chi %0d psi %0d clon %0d clat %0d",
                     $time, want.face, $signed(want.chi), $signed(want.psi), want.clon,
                     $signed(want.clat));
            $display("%0t:            actual face %0d chi %0d psi %0d clon %0d clat %0d",
                     $time, face_i, chi_i, psi_i, center_longitude_i, center_latitude_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) proj_q.push_back(project(longitude_i, latitude_i));
      pending_o = proj_q.size();
    end
  end

endmodule

@@ bench/cube_face_tangent_projection_top_tb.sv @@
// Testbench top: stimulus, clock, reset, watchdog and verdict for the cube face projection.
module cube_face_tangent_projection_top_tb;
  import cftp_pkg::*;

  localparam int N_RANDOM  = 700;
  localparam int WD_LIMIT  = 3000;  // longest sender gap plus pipeline latency, with margin
  localparam int DRAIN_CYC = 40;    // pipeline is 31 deep

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [ANGLE_W-1:0]         lon;
  logic signed [ANGLE_W-1:0]  lat;
  logic                       done;
  logic [FACE_W-1:0]          face;
  logic signed [COORD_W-1:0]  chi, psi;
  logic [LON_W-1:0]           clon;
  logic signed [LAT_W-1:0]    clat;
  int                         fails, pending;
  int                         idle_cycles;

  cube_face_tangent_projection_top i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .longitude_i(lon), .latitude_i(lat),
    .done_o(done), .face_o(face), .chi_o(chi), .psi_o(psi),
    .center_longitude_o(clon), .center_latitude_o(clat)
  );

  // watches both channels and keeps the expected results
  cftp_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .longitude_i(lon), .latitude_i(lat),
    .done_i(done), .face_i(face), .chi_i(chi), .psi_i(psi),
    .center_longitude_i(clon), .center_latitude_i(clat),
    .fail_count_o(fails), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with neither an item taken nor a result delivered
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("cube_face_tangent_projection_top regression: fail");
        $finish;
      end
    end
  end

  // present one item from a falling edge and hold it until taken
  task automatic send_item(input logic [ANGLE_W-1:0] lo, input logic [ANGLE_W-1:0] la);
    start <= 1'b1;
    lon   <= lo;
    lat   <= la;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // mostly back to back, some short gaps, a few long ones
  task automatic idle_gap();
    int g;
    int r;
    r = $urandom_range(99);
    if (r < 55) g = 0;
    else if (r < 93) g = $urandom_range(1, 4);
    else g = $urandom_range(10, 60);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  initial begin
    logic [ANGLE_W-1:0] la;
    start = 1'b0;
    lon   = '0;
    lat   = '0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: face centers, poles, octant and quadrant borders, edge/corner ties
    send_item(16'd0, 16'd0);
    send_item(16'd16384, 16'd0);
    send_item(16'd32768, 16'd0);
    send_item(16'd49152, 16'd0);
    send_item(16'hFFFF, 16'd0);
    send_item(16'd0, 16'd16384);       // north pole
    send_item(16'd12345, 16'hC000);    // south pole
    send_item(16'd8192, 16'd0);        // l and m tie
    send_item(16'd24576, 16'd0);
    send_item(16'd40960, 16'd0);
    send_item(16'd57344, 16'd0);
    send_item(16'd0, 16'd8192);        // l and n tie
    send_item(16'd0, 16'hE000);
    send_item(16'd8192, 16'd6270);     // near a cube corner
    send_item(16'd40960, 16'hE782);
    send_item(16'hFFFF, 16'h7FFF);     // latitude past 90 degrees
    send_item(16'hAAAA, 16'h8000);
    send_item(16'h5555, 16'h4001);
    send_item(16'd1, 16'hBFFF);
    send_item(16'd32767, 16'h2AAA);
    send_item(16'd16385, 16'd1);
    idle_gap();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 8 == 7) la = 16'($urandom());  // full latitude field, beyond the poles too
      else la = 16'($urandom_range(32768)) - 16'd16384;
      send_item(16'($urandom()), la);
      // let the pipeline drain completely once, mid run
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end else begin
        idle_gap();
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (fails == 0) $display("cube_face_tangent_projection_top regression: pass");
    else $display("cube_face_tangent_projection_top regression: fail");
    $finish;
  end

endmodule
